[design/bib_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bib_pkg
// Shared widths and sizes for the bilinear interval bound block.
// ----------------------------------------------------------------------------
package bib_pkg;

	localparam int unsigned FIELD_W     = 32;  // Q16.16 input fields
	localparam int unsigned PROD_W      = 64;  // corner product a*b
	localparam int unsigned HALF_W      = 32;  // split point of a corner product
	localparam int unsigned WIDE_W      = 96;  // w*a*b before scaling
	localparam int unsigned SUM_W       = 48;  // output sums
	localparam int unsigned EXT_W       = 64;  // accumulator view before trimming to SUM_W
	localparam int unsigned QUEUE_DEPTH = 8;
	localparam int unsigned QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage : bib_pkg
`default_nettype wire

[design/bib_term_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bib_term_if
// Input channel: one bilinear term per word.
// ----------------------------------------------------------------------------
interface bib_term_if;

	logic                                valid;
	logic                                ready;
	logic signed [bib_pkg::FIELD_W-1:0]  weight;
	logic signed [bib_pkg::FIELD_W-1:0]  first_lower;
	logic signed [bib_pkg::FIELD_W-1:0]  first_upper;
	logic signed [bib_pkg::FIELD_W-1:0]  second_lower;
	logic signed [bib_pkg::FIELD_W-1:0]  second_upper;
	logic                                last_term;

	modport source (
		output valid, weight, first_lower, first_upper, second_lower, second_upper, last_term,
		input  ready
	);

	modport sink (
		input  valid, weight, first_lower, first_upper, second_lower, second_upper, last_term,
		output ready
	);

endinterface : bib_term_if
`default_nettype wire

[design/bib_bound_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bib_bound_if
// Output channel: running lower and upper bounds, one word per term.
// ----------------------------------------------------------------------------
interface bib_bound_if;

	logic                              valid;
	logic                              ready;
	logic signed [bib_pkg::SUM_W-1:0]  lower_sum;
	logic signed [bib_pkg::SUM_W-1:0]  upper_sum;
	logic                              run_done;
	logic                              saturated;

	modport source (
		output valid, lower_sum, upper_sum, run_done, saturated,
		input  ready
	);

	modport sink (
		input  valid, lower_sum, upper_sum, run_done, saturated,
		output ready
	);

endinterface : bib_bound_if
`default_nettype wire

[design/bilinear_interval_bound_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_interval_bound_top
// Running interval bound of a quadratic function, one bilinear term per word.
// ----------------------------------------------------------------------------
// Each term word carries a weight and two variable bound pairs in signed
// Q16.16; each produces one bound word with the running lower and upper sums
// in Q32.16, the sticky saturation flag, and run_done copied from last_term
// (the sums clear after it). One word per clock is sustained while the output
// side is not stalled: the arithmetic runs in a five-stage pipeline and only
// the saturating accumulate depends on the previous term. A term passes
// through the pipeline, the queue and the output register. An eight-entry
// queue between the pipeline and the accumulators absorbs output stalls;
// terms are refused only when eight are already in flight or waiting.
module bilinear_interval_bound_top #(
	parameter int unsigned FRAC_BITS = 16,
	parameter int unsigned ACC_WIDTH = 48
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	bib_term_if.sink     terms,
	bib_bound_if.source  bounds
);

	localparam int unsigned QW = 2 * ACC_WIDTH + 2;

	logic          push, pop, q_valid;
	logic [QW-1:0] push_data, q_data;

	bib_front #(
		.FRAC_BITS (FRAC_BITS),
		.ACC_WIDTH (ACC_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.terms     (terms),
		.pop       (pop),
		.push      (push),
		.push_data (push_data)
	);

	bib_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	bib_back #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.pop     (pop),
		.bounds  (bounds)
	);

endmodule : bilinear_interval_bound_top
`default_nettype wire

[design/bib_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bib_front
// Five-stage term pipeline: corner products, min/max pick, weight partial
// products, product assembly, floor scaling with saturation. Never stalls;
// admission is limited by credits against the queue.
// ----------------------------------------------------------------------------
module bib_front #(
	parameter int unsigned FRAC_BITS = 16,
	parameter int unsigned ACC_WIDTH = 48
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	bib_term_if.sink                        terms,
	input  wire logic                       pop,
	output logic                            push,
	output logic [2*ACC_WIDTH+1:0]          push_data
);

	localparam int unsigned SHIFT = 2 * FRAC_BITS;
	localparam int unsigned TOP_W = bib_pkg::WIDE_W - ACC_WIDTH + 1;

	typedef logic signed [bib_pkg::FIELD_W-1:0] field_t;
	typedef logic signed [bib_pkg::PROD_W-1:0]  prod_t;
	typedef logic signed [bib_pkg::WIDE_W-1:0]  wide_t;
	typedef logic signed [ACC_WIDTH-1:0]        acc_t;

	function automatic logic [ACC_WIDTH:0] scale_sat(input wide_t prod);
		wide_t            q;
		logic [TOP_W-1:0] top;
		q   = prod >>> SHIFT;
		top = q[bib_pkg::WIDE_W-1:ACC_WIDTH-1];
		if (&top || ~|top) begin
			return {1'b0, q[ACC_WIDTH-1:0]};
		end else if (q[bib_pkg::WIDE_W-1]) begin
			return {1'b1, 1'b1, {(ACC_WIDTH-1){1'b0}}};
		end else begin
			return {1'b1, 1'b0, {(ACC_WIDTH-1){1'b1}}};
		end
	endfunction

	logic                      accept;
	logic [bib_pkg::QCNT_W-1:0] credit_q;

	logic   valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic   last_s1, last_s2, last_s3, last_s4, last_s5;
	field_t w_s1, w_s2;
	prod_t  c0_s1, c1_s1, c2_s1, c3_s1;
	prod_t  lo_p_s2, hi_p_s2;
	logic signed [bib_pkg::PROD_W:0]   lo_pl_s3, hi_pl_s3;
	logic signed [bib_pkg::PROD_W-1:0] lo_ph_s3, hi_ph_s3;
	wide_t  lo_full_s4, hi_full_s4;
	acc_t   tlo_s5, thi_s5;
	logic   sat_s5;

	prod_t  min01, min23, max01, max23, pmin, pmax;
	logic [ACC_WIDTH:0] lo_scaled, hi_scaled;

	assign terms.ready = credit_q < bib_pkg::QCNT_W'(bib_pkg::QUEUE_DEPTH);
	assign accept      = terms.valid && terms.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + bib_pkg::QCNT_W'(accept) - bib_pkg::QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// corner extremes
	always_comb begin
		min01 = (c0_s1 < c1_s1) ? c0_s1 : c1_s1;
		max01 = (c0_s1 > c1_s1) ? c0_s1 : c1_s1;
		min23 = (c2_s1 < c3_s1) ? c2_s1 : c3_s1;
		max23 = (c2_s1 > c3_s1) ? c2_s1 : c3_s1;
		pmin  = (min01 < min23) ? min01 : min23;
		pmax  = (max01 > max23) ? max01 : max23;
	end

	assign lo_scaled = scale_sat(lo_full_s4);
	assign hi_scaled = scale_sat(hi_full_s4);

	always_ff @(posedge clk) begin
		c0_s1   <= terms.first_lower * terms.second_lower;
		c1_s1   <= terms.first_lower * terms.second_upper;
		c2_s1   <= terms.first_upper * terms.second_lower;
		c3_s1   <= terms.first_upper * terms.second_upper;
		w_s1    <= terms.weight;
		last_s1 <= terms.last_term;

		lo_p_s2 <= w_s1[bib_pkg::FIELD_W-1] ? pmax : pmin;
		hi_p_s2 <= w_s1[bib_pkg::FIELD_W-1] ? pmin : pmax;
		w_s2    <= w_s1;
		last_s2 <= last_s1;

		lo_pl_s3 <= $signed({1'b0, lo_p_s2[bib_pkg::HALF_W-1:0]}) * w_s2;
		hi_pl_s3 <= $signed({1'b0, hi_p_s2[bib_pkg::HALF_W-1:0]}) * w_s2;
		lo_ph_s3 <= $signed(lo_p_s2[bib_pkg::PROD_W-1:bib_pkg::HALF_W]) * w_s2;
		hi_ph_s3 <= $signed(hi_p_s2[bib_pkg::PROD_W-1:bib_pkg::HALF_W]) * w_s2;
		last_s3  <= last_s2;

		lo_full_s4 <= (bib_pkg::WIDE_W'(lo_ph_s3) <<< bib_pkg::HALF_W)
			+ bib_pkg::WIDE_W'(lo_pl_s3);
		hi_full_s4 <= (bib_pkg::WIDE_W'(hi_ph_s3) <<< bib_pkg::HALF_W)
			+ bib_pkg::WIDE_W'(hi_pl_s3);
		last_s4    <= last_s3;

		tlo_s5  <= lo_scaled[ACC_WIDTH-1:0];
		thi_s5  <= hi_scaled[ACC_WIDTH-1:0];
		sat_s5  <= lo_scaled[ACC_WIDTH] | hi_scaled[ACC_WIDTH];
		last_s5 <= last_s4;
	end

	assign push      = valid_s5;
	assign push_data = {last_s5, sat_s5, thi_s5, tlo_s5};

endmodule : bib_front
`default_nettype wire

[design/bib_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bib_queue
// Small FIFO of scaled terms between the pipeline and the accumulator.
// Sized by the credit count, so it never sees a push while full.
// ----------------------------------------------------------------------------
module bib_queue #(
	parameter int unsigned WIDTH = 98
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic                  pop_valid,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int unsigned DEPTH = bib_pkg::QUEUE_DEPTH;

	logic [WIDTH-1:0]            mem_q [DEPTH];
	logic [bib_pkg::QIDX_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [bib_pkg::QCNT_W-1:0]  count_q;

	function automatic logic [bib_pkg::QIDX_W-1:0] next_ptr(
		input logic [bib_pkg::QIDX_W-1:0] p
	);
		return (p == bib_pkg::QIDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			count_q <= count_q + bib_pkg::QCNT_W'(push) - bib_pkg::QCNT_W'(pop);
		end
	end

	assign pop_valid = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

endmodule : bib_queue
`default_nettype wire

[design/bib_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bib_back
// Saturating lower/upper accumulators with sticky flag and the output
// register. Clears the run after a last term.
// ----------------------------------------------------------------------------
module bib_back #(
	parameter int unsigned ACC_WIDTH = 48
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     q_valid,
	input  wire logic [2*ACC_WIDTH+1:0]   q_data,
	output logic                          pop,
	bib_bound_if.source                   bounds
);

	typedef logic signed [ACC_WIDTH-1:0] acc_t;

	function automatic logic [ACC_WIDTH:0] sat_add(input acc_t x, input acc_t y);
		logic signed [ACC_WIDTH:0] s;
		s = {x[ACC_WIDTH-1], x} + {y[ACC_WIDTH-1], y};
		if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
			return {1'b1, s[ACC_WIDTH], {(ACC_WIDTH-1){~s[ACC_WIDTH]}}};
		end
		return {1'b0, s[ACC_WIDTH-1:0]};
	endfunction

	acc_t lo_acc_q, hi_acc_q;
	logic flag_q;

	logic                         out_valid_q;
	logic [bib_pkg::SUM_W-1:0]    lower_q, upper_q;
	logic                         done_q, sat_q;

	acc_t                 tlo, thi;
	logic                 t_sat, t_last;
	logic [ACC_WIDTH:0]   lo_new, hi_new;
	logic                 flag_new;
	logic signed [bib_pkg::EXT_W-1:0] lo_ext, hi_ext;

	assign {t_last, t_sat, thi, tlo} = q_data;
	assign lo_new   = sat_add(lo_acc_q, tlo);
	assign hi_new   = sat_add(hi_acc_q, thi);
	assign flag_new = flag_q | t_sat | lo_new[ACC_WIDTH] | hi_new[ACC_WIDTH];
	assign lo_ext   = bib_pkg::EXT_W'(acc_t'(lo_new[ACC_WIDTH-1:0]));
	assign hi_ext   = bib_pkg::EXT_W'(acc_t'(hi_new[ACC_WIDTH-1:0]));

	assign pop = q_valid && (!out_valid_q || bounds.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_acc_q    <= '0;
			hi_acc_q    <= '0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				lo_acc_q    <= t_last ? '0 : lo_new[ACC_WIDTH-1:0];
				hi_acc_q    <= t_last ? '0 : hi_new[ACC_WIDTH-1:0];
				flag_q      <= t_last ? 1'b0 : flag_new;
				out_valid_q <= 1'b1;
			end else if (bounds.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			lower_q <= lo_ext[bib_pkg::SUM_W-1:0];
			upper_q <= hi_ext[bib_pkg::SUM_W-1:0];
			done_q  <= t_last;
			sat_q   <= flag_new;
		end
	end

	assign bounds.valid     = out_valid_q;
	assign bounds.lower_sum = lower_q;
	assign bounds.upper_sum = upper_q;
	assign bounds.run_done  = done_q;
	assign bounds.saturated = sat_q;

endmodule : bib_back
`default_nettype wire

[design/bib_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bib_checker
// Port-level checks for the bilinear interval bound block.
// ----------------------------------------------------------------------------
module bib_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic signed [bib_pkg::SUM_W-1:0] lower_sum,
	input wire logic signed [bib_pkg::SUM_W-1:0] upper_sum,
	input wire logic                             run_done,
	input wire logic                             saturated
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("bound word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(lower_sum) && $stable(upper_sum)
			&& $stable(run_done) && $stable(saturated))
		else $error("bound word changed while stalled");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lower_sum <= upper_sum)
		else $error("lower sum above upper sum");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !run_done && saturated) ##1 (out_valid && out_ready)
		|-> saturated)
		else $error("saturation flag lost within a run");

endmodule : bib_checker

bind bilinear_interval_bound_top bib_checker u_bib_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (bounds.valid),
	.out_ready (bounds.ready),
	.lower_sum (bounds.lower_sum),
	.upper_sum (bounds.upper_sum),
	.run_done  (bounds.run_done),
	.saturated (bounds.saturated)
);
`default_nettype wire
